// ----- hw/rtl/psar_pkg.sv -----
// Shared types and constants for the scroll and address register unit.
`timescale 1ns / 1ps
`default_nettype none

package psar_pkg;

    // Command codes; codes 10 to 15 are unused and change nothing
    typedef enum logic [3:0] {
        CMD_CTRL_WR   = 4'd0,
        CMD_SCROLL_WR = 4'd1,
        CMD_ADDR_WR   = 4'd2,
        CMD_STATUS_RD = 4'd3,
        CMD_DATA_ACC  = 4'd4,
        CMD_INC_X     = 4'd5,
        CMD_INC_Y     = 4'd6,
        CMD_COPY_H    = 4'd7,
        CMD_COPY_V    = 4'd8,
        CMD_SOFT_RST  = 4'd9
    } cmd_t;

    localparam int unsigned ADDR_W     = 15;
    localparam int unsigned BUS_ADDR_W = 14;

    typedef logic [ADDR_W-1:0]     vaddr_t;
    typedef logic [BUS_ADDR_W-1:0] baddr_t;

    // Coarse Y rows: the last visible row wraps with a nametable flip,
    // the last encodable row wraps without one
    localparam logic [4:0] ROW_LAST_VISIBLE = 5'd29;
    localparam logic [4:0] ROW_LAST         = 5'd31;
    localparam logic [4:0] COARSE_X_LAST    = 5'd31;
    localparam logic [2:0] FINE_Y_LAST      = 3'd7;

    // Step sizes for data accesses
    localparam vaddr_t STEP_ONE  = 15'd1;
    localparam vaddr_t STEP_ROW  = 15'd32;

    // Fetch address bases
    localparam baddr_t NAMETABLE_BASE = 14'h2000;
    localparam baddr_t ATTR_BASE      = 14'h23C0;

endpackage

`default_nettype wire

// ----- hw/rtl/psar_if.sv -----
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps
`default_nettype none

interface psar_cmd_if;
    logic            valid;
    logic            ready;
    psar_pkg::cmd_t  cmd;
    logic [7:0]      data;

    modport source (output valid, output cmd, output data, input ready);
    modport sink   (input valid, input cmd, input data, output ready);
endinterface

interface psar_rsp_if;
    logic               valid;
    logic               ready;
    psar_pkg::baddr_t   access_addr;
    psar_pkg::vaddr_t   vram_addr;
    logic [2:0]         fine_scroll_x;
    logic               toggle;
    psar_pkg::baddr_t   nametable_addr;
    psar_pkg::baddr_t   attribute_addr;
    logic [2:0]         attr_shift;
    logic [2:0]         fine_y;

    modport source (
        output valid, output access_addr, output vram_addr, output fine_scroll_x,
        output toggle, output nametable_addr, output attribute_addr,
        output attr_shift, output fine_y, input ready
    );
    modport sink (
        input valid, input access_addr, input vram_addr, input fine_scroll_x,
        input toggle, input nametable_addr, input attribute_addr,
        input attr_shift, input fine_y, output ready
    );
endinterface

`default_nettype wire

// ----- hw/rtl/ppu_scroll_address_registers_top.sv -----
// Scroll and address register unit: current/temporary VRAM address and fetch addresses.
`timescale 1ns / 1ps
`default_nettype none

// Takes one command per clock and returns one result per command, in the cycle
// after acceptance. The command updates the current and temporary VRAM address,
// fine X, the write toggle and the step-size flag in a single pass of logic
// that lands in the state registers and the result register at the same edge.
// The result register frees itself when taken, so with the result side ready
// a command is accepted every cycle; a stalled result holds the command side
// for as long as it waits. Soft reset clears everything but the current address.

module ppu_scroll_address_registers_top (
    input  wire logic     clk,
    input  wire logic     rst_n,
    psar_cmd_if.sink      item,
    psar_rsp_if.source    result
);

    // Architectural state
    psar_pkg::vaddr_t cur_addr_reg,  cur_addr_next;
    psar_pkg::vaddr_t temp_addr_reg, temp_addr_next;
    logic [2:0]       fine_x_reg,    fine_x_next;
    logic             toggle_reg,    toggle_next;
    logic             step32_reg,    step32_next;

    // Result register
    logic             out_valid_reg;
    psar_pkg::baddr_t access_reg,    access_next;
    psar_pkg::vaddr_t vram_reg;
    logic [2:0]       fine_sx_reg;
    logic             tog_out_reg;

    logic             accept;
    logic [4:0]       row;

    // Accept when the result register is empty or being drained
    assign item.ready = !out_valid_reg || result.ready;
    assign accept     = item.valid && item.ready;
    assign row        = cur_addr_reg[9:5];

    // Next state for the command in flight
    always_comb
    begin
        cur_addr_next  = cur_addr_reg;
        temp_addr_next = temp_addr_reg;
        fine_x_next    = fine_x_reg;
        toggle_next    = toggle_reg;
        step32_next    = step32_reg;
        access_next    = cur_addr_reg[psar_pkg::BUS_ADDR_W-1:0];
        case (item.cmd)
            psar_pkg::CMD_CTRL_WR:
            begin
                temp_addr_next[11:10] = item.data[1:0];
                step32_next           = item.data[2];
            end
            psar_pkg::CMD_SCROLL_WR:
            begin
                if (!toggle_reg)
                begin
                    temp_addr_next[4:0] = item.data[7:3];
                    fine_x_next         = item.data[2:0];
                    toggle_next         = 1'b1;
                end
                else
                begin
                    temp_addr_next[14:12] = item.data[2:0];
                    temp_addr_next[9:5]   = item.data[7:3];
                    toggle_next           = 1'b0;
                end
            end
            psar_pkg::CMD_ADDR_WR:
            begin
                if (!toggle_reg)
                begin
                    // High byte: bit 14 cleared, low byte kept
                    temp_addr_next = {1'b0, item.data[5:0], temp_addr_reg[7:0]};
                    toggle_next    = 1'b1;
                end
                else
                begin
                    temp_addr_next = {temp_addr_reg[14:8], item.data};
                    cur_addr_next  = {temp_addr_reg[14:8], item.data};
                    toggle_next    = 1'b0;
                end
            end
            psar_pkg::CMD_STATUS_RD:
            begin
                toggle_next = 1'b0;
            end
            psar_pkg::CMD_DATA_ACC:
            begin
                cur_addr_next = cur_addr_reg
                              + (step32_reg ? psar_pkg::STEP_ROW : psar_pkg::STEP_ONE);
            end
            psar_pkg::CMD_INC_X:
            begin
                if (cur_addr_reg[4:0] == psar_pkg::COARSE_X_LAST)
                begin
                    cur_addr_next[4:0] = 5'd0;
                    cur_addr_next[10]  = !cur_addr_reg[10];
                end
                else
                begin
                    cur_addr_next[4:0] = cur_addr_reg[4:0] + 5'd1;
                end
            end
            psar_pkg::CMD_INC_Y:
            begin
                if (cur_addr_reg[14:12] != psar_pkg::FINE_Y_LAST)
                begin
                    cur_addr_next[14:12] = cur_addr_reg[14:12] + 3'd1;
                end
                else
                begin
                    cur_addr_next[14:12] = 3'd0;
                    if (row == psar_pkg::ROW_LAST_VISIBLE)
                    begin
                        cur_addr_next[9:5] = 5'd0;
                        cur_addr_next[11]  = !cur_addr_reg[11];
                    end
                    else if (row == psar_pkg::ROW_LAST)
                    begin
                        cur_addr_next[9:5] = 5'd0;
                    end
                    else
                    begin
                        cur_addr_next[9:5] = row + 5'd1;
                    end
                end
            end
            psar_pkg::CMD_COPY_H:
            begin
                cur_addr_next[10]  = temp_addr_reg[10];
                cur_addr_next[4:0] = temp_addr_reg[4:0];
            end
            psar_pkg::CMD_COPY_V:
            begin
                cur_addr_next[14:11] = temp_addr_reg[14:11];
                cur_addr_next[9:5]   = temp_addr_reg[9:5];
            end
            psar_pkg::CMD_SOFT_RST:
            begin
                temp_addr_next = '0;
                fine_x_next    = 3'd0;
                toggle_next    = 1'b0;
                step32_next    = 1'b0;
            end
            default:
            begin
                cur_addr_next = cur_addr_reg;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_addr_reg  <= '0;
            temp_addr_reg <= '0;
            fine_x_reg    <= 3'd0;
            toggle_reg    <= 1'b0;
            step32_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                cur_addr_reg  <= cur_addr_next;
                temp_addr_reg <= temp_addr_next;
                fine_x_reg    <= fine_x_next;
                toggle_reg    <= toggle_next;
                step32_reg    <= step32_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, loaded with each accepted command
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            access_reg  <= access_next;
            vram_reg    <= cur_addr_next;
            fine_sx_reg <= fine_x_next;
            tog_out_reg <= toggle_next;
        end
    end

    // Fetch addresses derived from the registered address
    assign result.valid          = out_valid_reg;
    assign result.access_addr    = access_reg;
    assign result.vram_addr      = vram_reg;
    assign result.fine_scroll_x  = fine_sx_reg;
    assign result.toggle         = tog_out_reg;
    assign result.nametable_addr = psar_pkg::NAMETABLE_BASE | {2'b00, vram_reg[11:0]};
    assign result.attribute_addr = psar_pkg::ATTR_BASE
                                 | {2'b00, vram_reg[11:10], 4'b0000,
                                    vram_reg[9:7], vram_reg[4:2]};
    assign result.attr_shift     = {vram_reg[6], vram_reg[1], 1'b0};
    assign result.fine_y         = vram_reg[14:12];

endmodule

`default_nettype wire

// ----- bench/psar_scroll_checker.sv -----
// Scoreboard for the scroll/address register unit: predicts each result and compares.
`timescale 1ns / 1ps

module psar_scroll_checker
    import psar_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    psar_cmd_if        cmd_mon,
    psar_rsp_if        rsp_mon,
    output int unsigned mismatch_count,
    output int unsigned results_due
);

    typedef struct packed {
        baddr_t     access_addr;
        vaddr_t     vram_addr;
        logic [2:0] fine_scroll_x;
        logic       toggle;
        baddr_t     nametable_addr;
        baddr_t     attribute_addr;
        logic [2:0] attr_shift;
        logic [2:0] fine_y;
    } scroll_result_t;

    // Predicted register file
    vaddr_t     v_cur;
    vaddr_t     v_tmp;
    logic [2:0] fine_x_q;
    logic       second_write;
    logic       row_step;

    scroll_result_t pending_results[$];
    int unsigned    errors;

    // Apply one command to the predicted registers and form its result
    function automatic scroll_result_t step_registers(input cmd_t c, input logic [7:0] d);
        scroll_result_t r;
        logic [4:0]     row;
        r.access_addr = v_cur[BUS_ADDR_W-1:0];
        case (c)
            CMD_CTRL_WR: begin
                v_tmp[11:10] = d[1:0];
                row_step     = d[2];
            end
            CMD_SCROLL_WR: begin
                if (!second_write) begin
                    v_tmp[4:0] = d[7:3];
                    fine_x_q   = d[2:0];
                end else begin
                    v_tmp[14:12] = d[2:0];
                    v_tmp[9:5]   = d[7:3];
                end
                second_write = ~second_write;
            end
            CMD_ADDR_WR: begin
                if (!second_write) begin
                    v_tmp = {1'b0, d[5:0], v_tmp[7:0]};
                end else begin
                    v_tmp[7:0] = d;
                    v_cur      = v_tmp;
                end
                second_write = ~second_write;
            end
            CMD_STATUS_RD: second_write = 1'b0;
            CMD_DATA_ACC:  v_cur = v_cur + (row_step ? STEP_ROW : STEP_ONE);
            CMD_INC_X: begin
                // coarse X wraps into the horizontally adjacent nametable
                if (v_cur[4:0] == COARSE_X_LAST) begin
                    v_cur[4:0] = '0;
                    v_cur[10]  = ~v_cur[10];
                end else begin
                    v_cur = v_cur + STEP_ONE;
                end
            end
            CMD_INC_Y: begin
                if (v_cur[14:12] != FINE_Y_LAST) begin
                    v_cur[14:12] = v_cur[14:12] + 3'd1;
                end else begin
                    v_cur[14:12] = '0;
                    row = v_cur[9:5];
                    // bottom visible row flips vertically, row 31 wraps silently
                    if (row == ROW_LAST_VISIBLE) begin
                        row       = '0;
                        v_cur[11] = ~v_cur[11];
                    end else if (row == ROW_LAST) begin
                        row = '0;
                    end else begin
                        row = row + 5'd1;
                    end
                    v_cur[9:5] = row;
                end
            end
            CMD_COPY_H: begin
                v_cur[10]  = v_tmp[10];
                v_cur[4:0] = v_tmp[4:0];
            end
            CMD_COPY_V: begin
                v_cur[14:11] = v_tmp[14:11];
                v_cur[9:5]   = v_tmp[9:5];
            end
            CMD_SOFT_RST: begin
                v_tmp        = '0;
                fine_x_q     = '0;
                second_write = 1'b0;
                row_step     = 1'b0;
            end
            default: ;
        endcase
        r.vram_addr      = v_cur;
        r.fine_scroll_x  = fine_x_q;
        r.toggle         = second_write;
        r.nametable_addr = NAMETABLE_BASE | {2'b00, v_cur[11:0]};
        r.attribute_addr = ATTR_BASE | {2'b00, v_cur[11:10], 4'b0000, v_cur[9:7], v_cur[4:2]};
        r.attr_shift     = {v_cur[6], v_cur[1], 1'b0};
        r.fine_y         = v_cur[14:12];
        return r;
    endfunction

    task automatic check_field(input string label, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, label, want, got);
            errors++;
        end
    endtask

    // Predict on each command transaction, compare on each result transaction
    always @(posedge clk or negedge rst_n) begin
        scroll_result_t want;
        if (!rst_n) begin
            v_cur        = '0;
            v_tmp        = '0;
            fine_x_q     = '0;
            second_write = 1'b0;
            row_step     = 1'b0;
            errors       = 0;
            pending_results.delete();
            mismatch_count <= 0;
            results_due    <= 0;
        end else begin
            if (cmd_mon.valid && cmd_mon.ready)
                pending_results.push_back(step_registers(cmd_mon.cmd, cmd_mon.data));
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result transaction with no command outstanding, vram_addr 0x%0h",
                             $time, rsp_mon.vram_addr);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("access_addr", 16'(want.access_addr), 16'(rsp_mon.access_addr));
                    check_field("vram_addr", 16'(want.vram_addr), 16'(rsp_mon.vram_addr));
                    check_field("fine_scroll_x", 16'(want.fine_scroll_x),
                                16'(rsp_mon.fine_scroll_x));
                    check_field("toggle", 16'(want.toggle), 16'(rsp_mon.toggle));
                    check_field("nametable_addr", 16'(want.nametable_addr),
                                16'(rsp_mon.nametable_addr));
                    check_field("attribute_addr", 16'(want.attribute_addr),
                                16'(rsp_mon.attribute_addr));
                    check_field("attr_shift", 16'(want.attr_shift), 16'(rsp_mon.attr_shift));
                    check_field("fine_y", 16'(want.fine_y), 16'(rsp_mon.fine_y));
                end
            end
            mismatch_count <= errors;
            results_due    <= pending_results.size();
        end
    end

endmodule

// ----- bench/ppu_scroll_address_registers_top_tb.sv -----
// Stimulus, handshake pacing and verdict for the scroll/address register unit.
`timescale 1ns / 1ps

module ppu_scroll_address_registers_top_tb;
    import psar_pkg::*;

    localparam logic [3:0] CMD_FIRST_UNUSED = 4'd10;
    localparam logic [3:0] CMD_LAST_CODE    = 4'd15;
    localparam int unsigned RANDOM_ITEMS    = 950;
    localparam int unsigned QUIET_TAIL      = 100;
    localparam int unsigned IDLE_LIMIT      = 500;

    logic clk;
    logic rst_n;
    logic quiet;
    int unsigned stall_left;
    int unsigned idle_cycles;
    int unsigned mismatch_count;
    int unsigned results_due;
    int unsigned cmds_sent;

    psar_cmd_if item_ch();
    psar_rsp_if result_ch();

    ppu_scroll_address_registers_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    psar_scroll_checker scoreboard (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd_mon        (item_ch),
        .rsp_mon        (result_ch),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    always #5 clk = ~clk;

    // Result-side backpressure in bursts of random length
    always @(posedge clk) begin
        if (!rst_n) begin
            result_ch.ready <= 1'b0;
            stall_left      <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 9) == 0) begin
            result_ch.ready <= 1'b0;
            stall_left      <= $urandom_range(0, 15);
        end else begin
            result_ch.ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transaction on either channel
    always @(posedge clk) begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL ppu_scroll_address_registers_top");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    // One command transaction, with an occasional source-side gap first
    task automatic send(input cmd_t c, input logic [7:0] d);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.cmd   <= c;
        item_ch.data  <= d;
        do @(posedge clk); while (!item_ch.ready);
        cmds_sent++;
    endtask

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Random mix of well-formed register sequences, render bursts and noise
    task automatic random_episode();
        int unsigned kind;
        int unsigned n;
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
            // scroll setup as done before a frame
            if ($urandom_range(0, 1) == 0) send(CMD_STATUS_RD, rand_byte());
            send(CMD_CTRL_WR, rand_byte());
            send(CMD_SCROLL_WR, rand_byte());
            send(CMD_SCROLL_WR, rand_byte());
            send(CMD_COPY_V, rand_byte());
            send(CMD_COPY_H, rand_byte());
        end else if (kind < 5) begin
            // address setup followed by data accesses
            if ($urandom_range(0, 1) == 0) send(CMD_STATUS_RD, rand_byte());
            if ($urandom_range(0, 2) == 0) send(CMD_CTRL_WR, rand_byte());
            send(CMD_ADDR_WR, rand_byte());
            send(CMD_ADDR_WR, rand_byte());
            n = $urandom_range(1, 8);
            repeat (n) send(CMD_DATA_ACC, rand_byte());
        end else if (kind < 8) begin
            // rendering: coarse X steps, Y steps, horizontal and vertical reloads
            n = $urandom_range(4, 24);
            repeat (n) begin
                case ($urandom_range(0, 5))
                    0, 1:    send(CMD_INC_X, rand_byte());
                    2, 3:    send(CMD_INC_Y, rand_byte());
                    4:       send(CMD_COPY_H, rand_byte());
                    default: send(CMD_COPY_V, rand_byte());
                endcase
            end
        end else if (kind == 8) begin
            // any command code, including the unused ones
            n = $urandom_range(1, 6);
            repeat (n) send(cmd_t'($urandom_range(0, CMD_LAST_CODE)), rand_byte());
        end else begin
            // broken sequences: pair interrupted by a status read or soft reset
            send($urandom_range(0, 1) ? CMD_SCROLL_WR : CMD_ADDR_WR, rand_byte());
            send($urandom_range(0, 1) ? CMD_STATUS_RD : CMD_SOFT_RST, rand_byte());
            if ($urandom_range(0, 1) == 0) send(CMD_ADDR_WR, rand_byte());
        end
    endtask

    initial begin
        int unsigned random_start;
        clk             = 1'b0;
        rst_n           = 1'b0;
        quiet           = 1'b0;
        cmds_sent       = 0;
        item_ch.valid   = 1'b0;
        item_ch.cmd     = CMD_STATUS_RD;
        item_ch.data    = 8'h00;
        result_ch.ready = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: wraps at every boundary, step sizes, toggle handling
        send(CMD_STATUS_RD, 8'h00);
        send(CMD_CTRL_WR, 8'hFF);
        send(CMD_SCROLL_WR, 8'hFF);
        send(CMD_SCROLL_WR, 8'hEF);
        send(CMD_COPY_H, 8'h00);
        send(CMD_COPY_V, 8'hFF);
        send(CMD_INC_X, 8'h00);
        send(CMD_INC_Y, 8'h00);
        send(CMD_DATA_ACC, 8'h00);
        send(CMD_ADDR_WR, 8'hFF);
        send(CMD_ADDR_WR, 8'hFF);
        send(CMD_DATA_ACC, 8'hFF);
        send(CMD_SCROLL_WR, 8'hFF);
        send(CMD_SCROLL_WR, 8'hFF);
        send(CMD_COPY_V, 8'h00);
        send(CMD_COPY_H, 8'h00);
        send(CMD_CTRL_WR, 8'h03);
        send(CMD_DATA_ACC, 8'h00);
        send(CMD_COPY_V, 8'h00);
        send(CMD_INC_Y, 8'h00);
        send(CMD_SCROLL_WR, 8'h00);
        send(CMD_STATUS_RD, 8'hFF);
        send(CMD_SCROLL_WR, 8'hF7);
        send(CMD_SCROLL_WR, 8'hF7);
        send(CMD_COPY_V, 8'h00);
        send(CMD_INC_Y, 8'h00);
        send(cmd_t'(CMD_FIRST_UNUSED), 8'hFF);
        send(cmd_t'(CMD_LAST_CODE), 8'h00);
        send(CMD_SOFT_RST, 8'hFF);

        // Random part; the tail runs without idling on either side
        random_start = cmds_sent;
        while (cmds_sent - random_start < RANDOM_ITEMS) begin
            if (cmds_sent - random_start >= RANDOM_ITEMS - QUIET_TAIL)
                quiet = 1'b1;
            random_episode();
        end
        item_ch.valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (results_due != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && results_due == 0)
            $display("PASS ppu_scroll_address_registers_top");
        else
            $display("FAIL ppu_scroll_address_registers_top");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/psar_pkg.sv
hw/rtl/psar_if.sv
hw/rtl/ppu_scroll_address_registers_top.sv
bench/psar_scroll_checker.sv
bench/ppu_scroll_address_registers_top_tb.sv
